FILE: hdl/cbt_pkg.sv
// shared types, constants and elaboration-time helpers for the cubic b-spline tessellator
// no dependencies
package cbt_pkg;

  localparam int FieldW          = 16;
  localparam int QuoW            = 15;
  localparam int SegmentsDefault = 20;

  typedef logic signed [FieldW-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   restart;
  } point_t;

  typedef struct packed {
    coord_t curve_x;
    coord_t curve_y;
    logic   segment_end;
  } curve_t;

  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

  // index 0 is the oldest held point, index 3 the incoming one
  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } seg_t;

  // scaled basis weight k for step j of s, over the denominator 6*s^3
  function automatic longint basis_weight(input longint s, input longint j, input int k);
    longint r;
    longint w;
    r = s - j;
    unique case (k)
      0: w = r * r * r;
      1: w = 3 * j * j * j - 6 * j * j * s + 4 * s * s * s;
      2: w = -3 * j * j * j + 3 * j * j * s + 3 * j * s * s + s * s * s;
      default: w = j * j * j;
    endcase
    return w;
  endfunction

  function automatic int weight_w(input int s);
    return $clog2(4 * s * s * s + 1);
  endfunction

  // width of the rounding numerator 2n + d
  function automatic int num_w(input int s);
    return weight_w(s) + FieldW + 4;
  endfunction

endpackage

FILE: hdl/cbt_window.sv
// control point window, restart handling and per-segment step sequencer
// depends on cbt_pkg
module cbt_window #(
  parameter int SEGMENTS = cbt_pkg::SegmentsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             point_valid,
  output logic                             point_ready,
  input  cbt_pkg::point_t                  point,
  input  logic                             en,
  output cbt_pkg::pipe_ctl_t               issue,
  output logic [$clog2(SEGMENTS+1)-1:0]    idx,
  output cbt_pkg::seg_t                    seg
);
  import cbt_pkg::*;

  localparam int JW = $clog2(SEGMENTS + 1);
  localparam logic [JW-1:0] JLast = JW'(SEGMENTS);

  coord_t          win_x [3];
  coord_t          win_y [3];
  logic [1:0]      held;
  logic            busy;
  logic [JW-1:0]   j;
  logic [1:0]      held_eff;
  logic            accept;
  logic            fill;
  logic            produce;

  assign held_eff    = point.restart ? 2'd0 : held;
  assign fill        = held_eff != 2'd3;
  assign point_ready = !busy || (en && j == JLast);
  assign accept      = point_valid && point_ready;
  assign produce     = accept && !fill;

  assign issue.valid = busy;
  assign issue.last  = (j == JLast);
  assign idx         = j;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 2'd0;
      busy <= 1'b0;
      j    <= '0;
    end else begin
      if (accept && fill) begin
        held <= held_eff + 2'd1;
      end
      if (produce) begin
        busy <= 1'b1;
        j    <= '0;
      end else if (en && busy) begin
        if (j == JLast) begin
          busy <= 1'b0;
        end else begin
          j <= j + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (fill) begin
        win_x[held_eff] <= point.point_x;
        win_y[held_eff] <= point.point_y;
      end else begin
        seg.x    <= {point.point_x, win_x[2], win_x[1], win_x[0]};
        seg.y    <= {point.point_y, win_y[2], win_y[1], win_y[0]};
        win_x[0] <= win_x[1];
        win_y[0] <= win_y[1];
        win_x[1] <= win_x[2];
        win_y[1] <= win_y[2];
        win_x[2] <= point.point_x;
        win_y[2] <= point.point_y;
      end
    end
  end

  // a stalled run keeps its step
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && !en) |=> (busy && $stable(j)))
    else $error("step counter moved while stalled");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (j <= JLast))
    else $error("step counter beyond last step");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    produce |=> (busy && j == '0))
    else $error("full window did not start a run");

endmodule

FILE: hdl/cbt_eval.sv
// basis weight lookup, weighted sums and rounding numerator, four register stages
// depends on cbt_pkg
module cbt_eval #(
  parameter int SEGMENTS = cbt_pkg::SegmentsDefault
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  cbt_pkg::pipe_ctl_t                           issue,
  input  logic [$clog2(SEGMENTS+1)-1:0]                idx,
  input  cbt_pkg::seg_t                                seg,
  output cbt_pkg::pipe_ctl_t                           ctl,
  output logic signed [cbt_pkg::num_w(SEGMENTS)-1:0]   num_x,
  output logic signed [cbt_pkg::num_w(SEGMENTS)-1:0]   num_y
);
  import cbt_pkg::*;

  localparam int WW   = weight_w(SEGMENTS);
  localparam int PW   = WW + FieldW + 1;
  localparam int NW   = PW + 2;
  localparam int NumW = num_w(SEGMENTS);
  localparam logic signed [NumW-1:0] DenN =
    NumW'(6 * longint'(SEGMENTS) * SEGMENTS * SEGMENTS);

  logic [WW-1:0]          wtab [SEGMENTS+1][4];
  pipe_ctl_t              a_ctl, b_ctl, c_ctl;
  logic [WW-1:0]          a_w [4];
  seg_t                   a_seg;
  logic signed [WW:0]     a_ws [4];
  logic signed [PW-1:0]   b_px [4];
  logic signed [PW-1:0]   b_py [4];
  logic signed [NW-1:0]   c_nx, c_ny;

  for (genvar g = 0; g <= SEGMENTS; g++) begin : g_row
    for (genvar k = 0; k < 4; k++) begin : g_col
      assign wtab[g][k] = WW'(basis_weight(SEGMENTS, g, k));
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_ws
    assign a_ws[k] = {1'b0, a_w[k]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
      b_ctl <= '0;
      c_ctl <= '0;
      ctl   <= '0;
    end else if (en) begin
      a_ctl <= issue;
      b_ctl <= a_ctl;
      c_ctl <= b_ctl;
      ctl   <= c_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        a_w[k]  <= wtab[idx][k];
        b_px[k] <= a_ws[k] * $signed(a_seg.x[k]);
        b_py[k] <= a_ws[k] * $signed(a_seg.y[k]);
      end
      a_seg <= seg;
      c_nx  <= NW'(b_px[0]) + NW'(b_px[1]) + NW'(b_px[2]) + NW'(b_px[3]);
      c_ny  <= NW'(b_py[0]) + NW'(b_py[1]) + NW'(b_py[2]) + NW'(b_py[3]);
      num_x <= NumW'(2 * c_nx + DenN);
      num_y <= NumW'(2 * c_ny + DenN);
    end
  end

endmodule

FILE: hdl/cbt_div.sv
// division of the rounding numerator by the constant 12*segments^3, truncating toward zero
// reciprocal estimate from the high bits, then a remainder compare; depends on cbt_pkg
module cbt_div #(
  parameter int SEGMENTS = cbt_pkg::SegmentsDefault
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  cbt_pkg::pipe_ctl_t                           ctl_in,
  input  logic signed [cbt_pkg::num_w(SEGMENTS)-1:0]   num_x,
  input  logic signed [cbt_pkg::num_w(SEGMENTS)-1:0]   num_y,
  output cbt_pkg::pipe_ctl_t                           ctl_out,
  output cbt_pkg::coord_t                              quo_x,
  output cbt_pkg::coord_t                              quo_y
);
  import cbt_pkg::*;

  localparam int     NumW      = num_w(SEGMENTS);
  localparam int     DivStages = 4;
  localparam longint Den2L     = 12 * longint'(SEGMENTS) * SEGMENTS * SEGMENTS;
  localparam int     DenW      = $clog2(Den2L);
  localparam int     HiSh      = DenW - 1;
  localparam int     HiW       = QuoW + 1;
  localparam int     RecW      = HiW;
  localparam logic [RecW-1:0] Recip = RecW'((longint'(1) << (RecW + HiSh)) / Den2L);
  localparam logic [DenW-1:0] DenC  = DenW'(Den2L);
  localparam logic [NumW-1:0] Den1N = NumW'(Den2L);
  localparam logic [NumW-1:0] Den2N = NumW'(2 * Den2L);

  logic signed [NumW-1:0] num [2];
  pipe_ctl_t              ctl [DivStages];
  coord_t                 res [2];

  assign num[0] = num_x;
  assign num[1] = num_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DivStages; s++) begin
        ctl[s] <= '0;
      end
    end else if (en) begin
      ctl[0] <= ctl_in;
      for (int s = 1; s < DivStages; s++) begin
        ctl[s] <= ctl[s-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic                 neg1, neg2, neg3, neg4;
    logic [NumW-1:0]      mag1, mag2, mag3, rem4;
    logic [HiW+RecW-1:0]  est2;
    logic [QuoW-1:0]      qe3, qe4;
    logic [QuoW+DenW-1:0] qc3;
    logic [1:0]           adj;
    logic [QuoW-1:0]      quo;

    // estimate is low by at most two
    assign adj = (rem4 >= Den2N) ? 2'd2 : ((rem4 >= Den1N) ? 2'd1 : 2'd0);
    assign quo = qe4 + QuoW'(adj);

    always_ff @(posedge clk) begin
      if (en) begin
        neg1 <= num[l][NumW-1];
        mag1 <= num[l][NumW-1] ? NumW'(-num[l]) : NumW'(num[l]);
        neg2 <= neg1;
        mag2 <= mag1;
        est2 <= mag1[HiSh +: HiW] * Recip;
        neg3 <= neg2;
        mag3 <= mag2;
        qe3  <= est2[RecW +: QuoW];
        qc3  <= est2[RecW +: QuoW] * DenC;
        neg4 <= neg3;
        qe4  <= qe3;
        rem4 <= mag3 - NumW'(qc3);
      end
    end

    assign res[l] = neg4 ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  assign ctl_out = ctl[DivStages-1];
  assign quo_x   = res[0];
  assign quo_y   = res[1];

endmodule

FILE: hdl/cubic_bspline_tessellator.sv
// top level of the uniform cubic b-spline tessellator
// depends on cbt_pkg, cbt_window, cbt_eval and cbt_div
//
// usage
//   control points enter on the point channel (point_valid/point_ready, payload point),
//   curve points leave on the curve channel (curve_valid/curve_ready, payload curve).
//   the first three points after reset, or from a point with restart set (which counts as the
//   first), only fill the window and produce nothing; each later point produces SEGMENTS+1
//   curve points, the last one flagged with segment_end, and then slides the window by one.
// pipeline and throughput
//   a run's first curve point passes the cbt_window step registers, the cbt_eval and cbt_div
//   stages and the curve output register. a run issues one step per cycle from the step
//   counter in cbt_window while the curve channel does not stall, so a point that completes
//   the window yields SEGMENTS+1 steps; the next point is taken in the cycle of the last step,
//   giving one curve point every cycle. fill-only points are taken while no run is issuing.
// reset
//   rst is synchronous; it empties the window and drops every step in flight.
// stall
//   while the curve transaction waits, the whole pipeline and the step counter hold;
//   point_ready stays high whenever no run is issuing.
module cubic_bspline_tessellator #(
  parameter int SEGMENTS = cbt_pkg::SegmentsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  output logic             point_ready,
  input  cbt_pkg::point_t  point,
  output logic             curve_valid,
  input  logic             curve_ready,
  output cbt_pkg::curve_t  curve
);
  import cbt_pkg::*;

  localparam int JW   = $clog2(SEGMENTS + 1);
  localparam int NumW = num_w(SEGMENTS);

  logic                   en;
  pipe_ctl_t              issue;
  logic [JW-1:0]          idx;
  seg_t                   seg;
  pipe_ctl_t              e_ctl;
  logic signed [NumW-1:0] num_x, num_y;
  pipe_ctl_t              d_ctl;
  coord_t                 quo_x, quo_y;

  assign en = !curve_valid || curve_ready;

  cbt_window #(.SEGMENTS(SEGMENTS)) u_window (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point),
    .en          (en),
    .issue       (issue),
    .idx         (idx),
    .seg         (seg)
  );

  cbt_eval #(.SEGMENTS(SEGMENTS)) u_eval (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .issue (issue),
    .idx   (idx),
    .seg   (seg),
    .ctl   (e_ctl),
    .num_x (num_x),
    .num_y (num_y)
  );

  cbt_div #(.SEGMENTS(SEGMENTS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (e_ctl),
    .num_x   (num_x),
    .num_y   (num_y),
    .ctl_out (d_ctl),
    .quo_x   (quo_x),
    .quo_y   (quo_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_valid <= 1'b0;
    end else if (en) begin
      curve_valid <= d_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      curve.curve_x     <= quo_x;
      curve.curve_y     <= quo_y;
      curve.segment_end <= d_ctl.last;
    end
  end

endmodule

FILE: dv/tb_cubic_bspline_tessellator.sv
// self-checking testbench for cubic_bspline_tessellator: directed table then random control points
// depends on cbt_pkg and the rtl top level; expected curve points come from an in-bench predictor
module tb_cubic_bspline_tessellator;
  import cbt_pkg::*;

  localparam int SEGMENTS     = 20;
  localparam int RANDOM_ITEMS = 145;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PRESSURE_AT  = 60;
  localparam int PRESSURE_LEN = 400;
  localparam int MAX_PRINTED  = 40;

  typedef struct {
    point_t p;
    bit     typed;
    coord_t tx;
    coord_t ty;
  } plan_row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   point_valid = 1'b0;
  logic   point_ready;
  point_t point = '0;
  logic   curve_valid;
  logic   curve_ready = 1'b0;
  curve_t curve;

  curve_t curve_due[$];
  longint win_x[3];
  longint win_y[3];
  int     held = 0;
  int     errors = 0;
  int     curves_seen = 0;
  int     cycle_count = 0;

  cubic_bspline_tessellator #(.SEGMENTS(SEGMENTS)) u_top (
    .clk(clk),
    .rst(rst),
    .point_valid(point_valid),
    .point_ready(point_ready),
    .point(point),
    .curve_valid(curve_valid),
    .curve_ready(curve_ready),
    .curve(curve)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < MAX_PRINTED)
      $display("mismatch at cycle %0d, %s: got %0d expected %0d", cycle_count, what, got, want);
    errors++;
  endtask

  // window update and curve points for one accepted control point
  function automatic void tessellate_point(input point_t p, input bit typed, input coord_t tx,
                                           input coord_t ty);
    longint s, d, j, b0, b1, b2, b3, nx, ny, px, py;
    curve_t c;
    s  = SEGMENTS;
    d  = 6 * s * s * s;
    px = longint'(signed'(p.point_x));
    py = longint'(signed'(p.point_y));
    if (p.restart) held = 0;
    if (held < 3) begin
      win_x[held] = px;
      win_y[held] = py;
      held++;
      return;
    end
    for (j = 0; j <= s; j++) begin
      b0 = (s - j) * (s - j) * (s - j);
      b3 = j * j * j;
      b1 = 3 * b3 - 6 * j * j * s + 4 * s * s * s;
      b2 = d - b0 - b1 - b3;
      nx = b0 * win_x[0] + b1 * win_x[1] + b2 * win_x[2] + b3 * px;
      ny = b0 * win_y[0] + b1 * win_y[1] + b2 * win_y[2] + b3 * py;
      // add one half, then truncate toward zero
      c.curve_x     = typed ? tx : coord_t'((2 * nx + d) / (2 * d));
      c.curve_y     = typed ? ty : coord_t'((2 * ny + d) / (2 * d));
      c.segment_end = (j == s);
      curve_due = {curve_due, c};
    end
    win_x[0] = win_x[1];
    win_y[0] = win_y[1];
    win_x[1] = win_x[2];
    win_y[1] = win_y[2];
    win_x[2] = px;
    win_y[2] = py;
  endfunction

  function automatic plan_row_t mk(input int x, input int y, input bit rs, input bit typed = 1'b0,
                                   input int tx = 0, input int ty = 0);
    plan_row_t r;
    r.p.point_x = coord_t'(x);
    r.p.point_y = coord_t'(y);
    r.p.restart = rs;
    r.typed     = typed;
    r.tx        = coord_t'(tx);
    r.ty        = coord_t'(ty);
    return r;
  endfunction

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return coord_t'(32767);
      1: return coord_t'(-32768);
      2: return coord_t'($urandom_range(0, 6) - 3);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer_point(input point_t p, input int gap);
    repeat (gap) @(negedge clk) point_valid <= 1'b0;
    @(negedge clk);
    point_valid <= 1'b1;
    point       <= p;
    do @(posedge clk); while (!point_ready);
  endtask

  // curve transaction checker
  always @(posedge clk) begin
    curve_t want;
    if (!rst && curve_valid && curve_ready) begin
      curves_seen++;
      if (curve_due.size() == 0) begin
        report_mismatch("unexpected curve point, curve_x", curve.curve_x, 0);
      end else begin
        want = curve_due.pop_front();
        if (curve.curve_x !== want.curve_x)
          report_mismatch("curve_x", curve.curve_x, want.curve_x);
        if (curve.curve_y !== want.curve_y)
          report_mismatch("curve_y", curve.curve_y, want.curve_y);
        if (curve.segment_end !== want.segment_end)
          report_mismatch("segment_end", curve.segment_end, want.segment_end);
      end
    end
  end

  // curve sink: random back-pressure, calm stretches and one long hold-off
  initial begin : curve_sink
    int hold;
    int calm;
    int r;
    bit pressed;
    hold    = 0;
    calm    = 0;
    pressed = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressed && curves_seen >= PRESSURE_AT) begin
        pressed = 1'b1;
        curve_ready <= 1'b0;
        repeat (PRESSURE_LEN) @(negedge clk);
      end else if (calm > 0) begin
        calm--;
        curve_ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        curve_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          calm = $urandom_range(30, 150);
          curve_ready <= 1'b1;
        end else if (r < 70) begin
          curve_ready <= 1'b1;
        end else if (r < 96) begin
          hold = $urandom_range(0, 2);
          curve_ready <= 1'b0;
        end else begin
          hold = $urandom_range(10, 40);
          curve_ready <= 1'b0;
        end
      end
    end
  end

  // point source: directed table, then random points
  initial begin : point_source
    plan_row_t plan[$];
    point_t    p;
    int        no_gap;
    int        gap;
    plan = '{
      mk(0, 0, 1'b0), mk(0, 0, 1'b0), mk(0, 0, 1'b0),
      mk(0, 0, 1'b0, 1'b1, 0, 0),
      // extremes, constant window gives the point back, the most negative value one higher
      mk(32767, -32768, 1'b1), mk(32767, -32768, 1'b0), mk(32767, -32768, 1'b0),
      mk(32767, -32768, 1'b0, 1'b1, 32767, -32767),
      mk(-32768, 32767, 1'b0), mk(-32768, 32767, 1'b0), mk(-32768, 32767, 1'b0),
      mk(-32768, 32767, 1'b0, 1'b1, -32767, 32767),
      // restart with a partly filled window
      mk(100, -100, 1'b1), mk(5, 7, 1'b0),
      mk(1, 2, 1'b1), mk(1, 2, 1'b0), mk(1, 2, 1'b0),
      mk(1, 2, 1'b0, 1'b1, 1, 2),
      // restart with a full window, then rounding of small negative values
      mk(-1, 1, 1'b1), mk(0, 0, 1'b0), mk(0, 0, 1'b0),
      mk(32767, 32767, 1'b0), mk(-32768, -32768, 1'b0),
      mk(21845, -21846, 1'b0), mk(-1, 0, 1'b0)
    };
    no_gap = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    foreach (plan[i]) begin
      offer_point(plan[i].p, pick_gap());
      tessellate_point(plan[i].p, plan[i].typed, plan[i].tx, plan[i].ty);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      p.point_x = rand_coord();
      p.point_y = rand_coord();
      p.restart = ($urandom_range(0, 99) < 5);
      if (no_gap > 0) begin
        no_gap--;
        gap = 0;
      end else if ($urandom_range(0, 99) < 4) begin
        no_gap = $urandom_range(8, 25);
        gap    = 0;
      end else begin
        gap = pick_gap();
      end
      offer_point(p, gap);
      tessellate_point(p, 1'b0, '0, '0);
    end
    @(negedge clk) point_valid <= 1'b0;
    while (curve_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
